@@ rtl/scfr_pkg.sv @@
// Shared types, constants and helpers for the sum/add-check frame receiver.
// Used by every module of the block but scfr_ram; depends on nothing else.
`timescale 1ns / 1ps

package scfr_pkg;

  // Payload geometry and the payload buffer memory (two banks of MAX_PAYLOAD bytes).
  localparam int MAX_PAYLOAD = 32;
  localparam int POS_W       = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = 6;
  localparam int RAM_DEPTH   = 2 * MAX_PAYLOAD;
  localparam int RAM_AW      = POS_W + 1;

  // Shortest burst that can hold a frame; the burst counter saturates here.
  localparam logic [2:0] MIN_BURST = 3'd7;

  // Frame queue between the parser and the result sequencer.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_BYTE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_BYTE = 4'd1;
  localparam logic [7:0] HEAD_BYTE_RST = 8'hAA;
  localparam logic [7:0] ADDR_BYTE_RST = 8'hFF;

  // Parser phases.
  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_ID   = 3'd1;
  localparam logic [2:0] PH_LEN  = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_SUM  = 3'd4;
  localparam logic [2:0] PH_ADD  = 3'd5;
  localparam logic [2:0] PH_DONE = 3'd6;
  localparam logic [2:0] PH_SKIP = 3'd7;

  // Result status codes.
  localparam logic [2:0] ST_NEW    = 3'd0;
  localparam logic [2:0] ST_REPEAT = 3'd1;
  localparam logic [2:0] ST_CSUM   = 3'd2;
  localparam logic [2:0] ST_LEN    = 3'd3;
  localparam logic [2:0] ST_SHORT  = 3'd4;
  localparam logic [2:0] ST_NOHDR  = 3'd5;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       burst_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [7:0]       frame_id;
    logic [LEN_W-1:0] payload_len;
    logic [POS_W-1:0] byte_index;
    logic [7:0]       data_byte;
    logic             last;
  } out_item_t;

  // One finished burst as handed from the parser to the result sequencer.
  // bank gives, per payload position, which memory bank holds the byte.
  typedef struct packed {
    logic [2:0]             status;
    logic [7:0]             frame_id;
    logic [LEN_W-1:0]       payload_len;
    logic [MAX_PAYLOAD-1:0] bank;
  } q_entry_t;

  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  typedef struct packed {
    logic              re;
    logic [RAM_AW-1:0] addr;
  } ram_rd_t;

  // True for the two statuses that deliver a payload.
  function automatic logic is_accept(input logic [2:0] status);
    return (status == ST_NEW) || (status == ST_REPEAT);
  endfunction

endpackage

@@ rtl/scfr_ram.sv @@
// Generic dual-read, single-write RAM with registered, enabled read ports.
// Stands alone; used for the payload buffer of the frame receiver.
`timescale 1ns / 1ps

module scfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports hold their data until the next enabled read.
  always_ff @(posedge clk) begin
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ rtl/scfr_queue.sv @@
// Short frame queue between the parser and the result sequencer.
// Depends on scfr_pkg for the entry type and depth.
`timescale 1ns / 1ps

module scfr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  scfr_pkg::q_entry_t push_entry,
  input  logic               pop,
  output scfr_pkg::q_entry_t head,
  output logic               full,
  output logic               empty
);

  scfr_pkg::q_entry_t                entries_r [scfr_pkg::Q_DEPTH];
  logic [scfr_pkg::Q_PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [scfr_pkg::Q_PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [scfr_pkg::Q_PTR_W:0]        count_r, count_nxt;

  assign full  = (count_r == (scfr_pkg::Q_PTR_W + 1)'(scfr_pkg::Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = entries_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == scfr_pkg::Q_PTR_W'(scfr_pkg::Q_DEPTH - 1)) ? '0 :
                   wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == scfr_pkg::Q_PTR_W'(scfr_pkg::Q_DEPTH - 1)) ? '0 :
                   rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + {{scfr_pkg::Q_PTR_W{1'b0}}, push}
                        - {{scfr_pkg::Q_PTR_W{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ rtl/scfr_front.sv @@
// Byte parser of the frame receiver: header hunt, checks, payload write and repeat compare.
// Depends on scfr_pkg; drives the payload RAM write port and one RAM read port.
`timescale 1ns / 1ps

module scfr_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  scfr_pkg::in_item_t in_data,
  input  logic [7:0]         head_byte,
  input  logic [7:0]         addr_byte,
  output scfr_pkg::ram_wr_t  wr,
  output scfr_pkg::ram_rd_t  cmp_rd,
  input  logic [7:0]         cmp_rdata,
  output logic               q_push,
  output scfr_pkg::q_entry_t q_entry,
  input  logic               q_full,
  input  logic               acc_done
);

  logic [2:0]                      phase_r, phase_nxt;
  logic [2:0]                      bc_r, bc_nxt;
  logic [5:0]                      fp_r, fp_nxt;
  logic                            pwh_r, pwh_nxt;
  logic [7:0]                      id_r, id_nxt;
  logic [7:0]                      len_r, len_nxt;
  logic [7:0]                      sum_r, sum_nxt;
  logic [7:0]                      add_r, add_nxt;
  logic [7:0]                      sumrx_r, sumrx_nxt;
  logic [7:0]                      addrx_r, addrx_nxt;
  logic                            same_r, same_nxt;
  logic [scfr_pkg::MAX_PAYLOAD-1:0] sel_r, sel_nxt;
  logic [scfr_pkg::MAX_PAYLOAD-1:0] vld_r, vld_nxt;
  logic [1:0]                      acc_cnt_r, acc_cnt_nxt;
  logic                            cmp_pend_r, cmp_pend_nxt;
  logic                            cmp_vld_r, cmp_vld_nxt;
  logic [7:0]                      cmp_byte_r, cmp_byte_nxt;

  logic                            accept;
  logic [7:0]                      b;
  logic [scfr_pkg::POS_W-1:0]      pos;
  logic [7:0]                      sum_abs, add_abs, hdr_sum, hdr_add;
  logic                            mismatch;
  logic [2:0]                      status;
  logic [scfr_pkg::MAX_PAYLOAD-1:0] len_mask;
  logic                            acc_inc;

  // Input stalls while the queue is full, or while a payload write could land in
  // a bank still owed to an older accepted frame (two accepted frames in flight).
  assign in_stall = q_full || ((phase_r == scfr_pkg::PH_DATA) && (acc_cnt_r >= 2'd2));
  assign accept   = in_valid && !in_stall;
  assign b        = in_data.rx_byte;
  assign pos      = fp_r[scfr_pkg::POS_W-1:0];

  // Running sums and the header preload (head and address absorbed in one go).
  assign sum_abs = sum_r + b;
  assign add_abs = add_r + sum_abs;
  assign hdr_sum = head_byte + addr_byte;
  assign hdr_add = head_byte + hdr_sum;

  // The previous payload byte reads as zero where it was cleared.
  assign mismatch = cmp_vld_r ? (cmp_rdata != cmp_byte_r) : (cmp_byte_r != 8'd0);

  // Positions covered by the current length.
  always_comb begin
    for (int k = 0; k < scfr_pkg::MAX_PAYLOAD; k++) begin
      len_mask[k] = (8'(k) < len_r);
    end
  end

  // Parser next state.
  always_comb begin
    phase_nxt    = phase_r;
    bc_nxt       = bc_r;
    fp_nxt       = fp_r;
    pwh_nxt      = pwh_r;
    id_nxt       = id_r;
    len_nxt      = len_r;
    sum_nxt      = sum_r;
    add_nxt      = add_r;
    sumrx_nxt    = sumrx_r;
    addrx_nxt    = addrx_r;
    sel_nxt      = sel_r;
    vld_nxt      = vld_r;
    cmp_byte_nxt = cmp_byte_r;
    cmp_vld_nxt  = cmp_vld_r;
    cmp_pend_nxt = 1'b0;
    same_nxt     = same_r & ~(cmp_pend_r & mismatch);
    acc_inc      = 1'b0;
    status       = scfr_pkg::ST_NOHDR;
    q_push       = 1'b0;
    q_entry      = '0;
    wr.we        = 1'b0;
    wr.addr      = {~sel_r[pos], pos};
    wr.data      = b;
    cmp_rd.re    = 1'b0;
    cmp_rd.addr  = {sel_r[pos], pos};

    if (accept) begin
      if (bc_r < scfr_pkg::MIN_BURST) begin
        bc_nxt = bc_r + 3'd1;
      end

      case (phase_r)
        scfr_pkg::PH_HUNT: begin
          if (pwh_r && (b == addr_byte)) begin
            sum_nxt   = hdr_sum;
            add_nxt   = hdr_add;
            phase_nxt = scfr_pkg::PH_ID;
          end
          pwh_nxt = (b == head_byte);
        end
        scfr_pkg::PH_ID: begin
          id_nxt    = b;
          sum_nxt   = sum_abs;
          add_nxt   = add_abs;
          phase_nxt = scfr_pkg::PH_LEN;
        end
        scfr_pkg::PH_LEN: begin
          len_nxt = b;
          sum_nxt = sum_abs;
          add_nxt = add_abs;
          fp_nxt  = '0;
          if (b > 8'(scfr_pkg::MAX_PAYLOAD)) begin
            phase_nxt = scfr_pkg::PH_SKIP;
          end else if (b == 8'd0) begin
            phase_nxt = scfr_pkg::PH_SUM;
          end else begin
            phase_nxt = scfr_pkg::PH_DATA;
          end
        end
        scfr_pkg::PH_DATA: begin
          // Store into the spare bank and fetch the previous byte for comparison.
          wr.we        = 1'b1;
          cmp_rd.re    = 1'b1;
          cmp_byte_nxt = b;
          cmp_vld_nxt  = vld_r[pos];
          cmp_pend_nxt = !in_data.burst_end;
          sum_nxt      = sum_abs;
          add_nxt      = add_abs;
          fp_nxt       = fp_r + 6'd1;
          if (({2'b00, fp_r} + 8'd1) >= len_r) begin
            phase_nxt = scfr_pkg::PH_SUM;
          end
        end
        scfr_pkg::PH_SUM: begin
          sumrx_nxt = b;
          phase_nxt = scfr_pkg::PH_ADD;
        end
        scfr_pkg::PH_ADD: begin
          addrx_nxt = b;
          phase_nxt = scfr_pkg::PH_DONE;
        end
        default: begin
        end
      endcase

      // Burst end: classify, hand the frame to the queue and clear burst state.
      if (in_data.burst_end) begin
        if (bc_nxt < scfr_pkg::MIN_BURST) begin
          status = scfr_pkg::ST_SHORT;
        end else if (phase_nxt == scfr_pkg::PH_HUNT) begin
          status = scfr_pkg::ST_NOHDR;
        end else if (phase_nxt != scfr_pkg::PH_DONE) begin
          status = scfr_pkg::ST_LEN;
        end else if ((add_nxt == 8'd0) || (sumrx_nxt != sum_nxt) ||
                     (addrx_nxt != add_nxt)) begin
          status = scfr_pkg::ST_CSUM;
        end else begin
          status = same_nxt ? scfr_pkg::ST_REPEAT : scfr_pkg::ST_NEW;
        end

        q_push         = 1'b1;
        q_entry.status = status;
        if (scfr_pkg::is_accept(status)) begin
          q_entry.frame_id    = id_r;
          q_entry.payload_len = len_r[scfr_pkg::LEN_W-1:0];
          q_entry.bank        = sel_r ^ len_mask;
          sel_nxt             = sel_r ^ len_mask;
          vld_nxt             = vld_r | len_mask;
          acc_inc             = 1'b1;
        end else begin
          q_entry.bank = sel_r;
          vld_nxt      = '0;
        end

        phase_nxt = scfr_pkg::PH_HUNT;
        bc_nxt    = '0;
        fp_nxt    = '0;
        pwh_nxt   = 1'b0;
        id_nxt    = '0;
        len_nxt   = '0;
        sum_nxt   = '0;
        add_nxt   = '0;
        sumrx_nxt = '0;
        addrx_nxt = '0;
        same_nxt  = 1'b1;
      end
    end

    acc_cnt_nxt = acc_cnt_r + {1'b0, acc_inc} - {1'b0, acc_done};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= scfr_pkg::PH_HUNT;
      bc_r       <= '0;
      fp_r       <= '0;
      pwh_r      <= 1'b0;
      id_r       <= '0;
      len_r      <= '0;
      sum_r      <= '0;
      add_r      <= '0;
      sumrx_r    <= '0;
      addrx_r    <= '0;
      same_r     <= 1'b1;
      sel_r      <= '0;
      vld_r      <= '0;
      acc_cnt_r  <= '0;
      cmp_pend_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      bc_r       <= bc_nxt;
      fp_r       <= fp_nxt;
      pwh_r      <= pwh_nxt;
      id_r       <= id_nxt;
      len_r      <= len_nxt;
      sum_r      <= sum_nxt;
      add_r      <= add_nxt;
      sumrx_r    <= sumrx_nxt;
      addrx_r    <= addrx_nxt;
      same_r     <= same_nxt;
      sel_r      <= sel_nxt;
      vld_r      <= vld_nxt;
      acc_cnt_r  <= acc_cnt_nxt;
      cmp_pend_r <= cmp_pend_nxt;
    end
  end

  // Compare operands need no reset.
  always_ff @(posedge clk) begin
    cmp_byte_r <= cmp_byte_nxt;
    cmp_vld_r  <= cmp_vld_nxt;
  end

  // The sequencer never finishes more accepted frames than were handed over.
  a_acc_done_counted: assert property (@(posedge clk) disable iff (!rst_n)
    acc_done |-> (acc_cnt_r != 2'd0))
    else $error("accepted frame finished with none outstanding");

  // A pending compare always follows a payload write of the previous cycle.
  a_cmp_follows_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_pend_r |-> $past(wr.we))
    else $error("payload compare without a preceding payload write");

endmodule

@@ rtl/scfr_back.sv @@
// Result sequencer of the frame receiver: expands queued frames into result transactions.
// Depends on scfr_pkg; drives one read port of the payload RAM.
`timescale 1ns / 1ps

module scfr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  scfr_pkg::q_entry_t  q_head,
  output logic                q_pop,
  output scfr_pkg::ram_rd_t   rd,
  input  logic [7:0]          rdata,
  output logic                acc_done,
  output logic                out_valid,
  input  logic                out_stall,
  output scfr_pkg::out_item_t out_data
);

  logic [5:0]                 k_r, k_nxt;
  logic                       s1_vld_r, s1_vld_nxt;
  scfr_pkg::out_item_t        s1_meta_r;
  logic                       s1_zero_r;
  logic                       out_vld_r, out_vld_nxt;
  scfr_pkg::out_item_t        out_r;

  logic                       s2_free, adv, s1_free, issue, is_last;
  logic [5:0]                 nres;
  logic [scfr_pkg::POS_W-1:0] kpos;
  scfr_pkg::out_item_t        s1_meta_nxt;
  scfr_pkg::out_item_t        out_nxt;

  // Two-stage pipe: RAM read stage, then the output register.
  assign s2_free = !out_vld_r || !out_stall;
  assign adv     = s1_vld_r && s2_free;
  assign s1_free = !s1_vld_r || adv;
  assign issue   = !q_empty && s1_free;

  // A frame gives one result per payload byte, or a single result without payload.
  assign nres    = (q_head.payload_len == '0) ? 6'd1 : q_head.payload_len;
  assign kpos    = k_r[scfr_pkg::POS_W-1:0];
  assign is_last = (k_r == (nres - 6'd1));

  assign rd.re    = issue && (q_head.payload_len != '0);
  assign rd.addr  = {q_head.bank[kpos], kpos};
  assign q_pop    = issue && is_last;
  assign acc_done = issue && is_last && scfr_pkg::is_accept(q_head.status);

  // Result fields for the read being issued.
  always_comb begin
    s1_meta_nxt.status      = q_head.status;
    s1_meta_nxt.frame_id    = q_head.frame_id;
    s1_meta_nxt.payload_len = q_head.payload_len;
    s1_meta_nxt.byte_index  = kpos;
    s1_meta_nxt.data_byte   = 8'd0;
    s1_meta_nxt.last        = is_last;
  end

  // Output register contents once the payload byte is back from the RAM.
  always_comb begin
    out_nxt           = s1_meta_r;
    out_nxt.data_byte = s1_zero_r ? 8'd0 : rdata;
  end

  // Control next state.
  always_comb begin
    k_nxt = k_r;
    if (issue) begin
      k_nxt = is_last ? 6'd0 : k_r + 6'd1;
    end
    s1_vld_nxt = issue ? 1'b1 : (adv ? 1'b0 : s1_vld_r);
    out_vld_nxt = s2_free ? s1_vld_r : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r       <= '0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      k_r       <= k_nxt;
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_meta_r <= s1_meta_nxt;
      s1_zero_r <= (q_head.payload_len == '0);
    end
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // Only a frame that is being read from the queue may be removed from it.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // Results that do not close a burst belong to accepted frames only.
  a_multi_only_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_r.last) |->
      ((out_r.status == scfr_pkg::ST_NEW) || (out_r.status == scfr_pkg::ST_REPEAT)))
    else $error("rejection produced more than one result");

endmodule

@@ rtl/sum_add_check_frame_receiver_top.sv @@
// Top level of the sum/add-check frame receiver: configuration registers and wiring.
// Depends on scfr_pkg, scfr_ram, scfr_queue, scfr_front and scfr_back.
`timescale 1ns / 1ps

// Usage:
// The input channel carries one received byte per transaction, with burst_end set
// on the last byte before line idle. The parser takes one byte per cycle while the
// input is not stalled; it finds the first head/address pair of a burst and checks
// id, length, payload and both check bytes. Only the burst-end byte produces
// results: one per payload byte for an accepted frame, otherwise a single status
// result, the final one with last set. Results leave one per cycle while the output
// is not stalled, after the frame queue, the RAM read stage and the output register.
// A two-entry frame queue lets the parser keep taking bytes while results drain;
// the input stalls only when that queue is full, or when a payload byte would land
// in a buffer bank that two accepted frames still waiting for output depend on.
// A stalled output holds its result and the pipe behind it fills, then the queue.
// The configuration channel is always ready; index 0 writes head_byte, index 1
// writes addr_byte, other indexes are ignored. Write only while the block is idle.
// Synchronous reset restores head 0xAA and address 0xFF, empties the queue and
// output, and marks the stored previous payload as all zeros; there is no
// clearing pass, so items are accepted right after reset.

module sum_add_check_frame_receiver_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  scfr_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output scfr_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [scfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                      cfg_data
);

  logic [7:0]          head_byte_r, head_byte_nxt;
  logic [7:0]          addr_byte_r, addr_byte_nxt;

  scfr_pkg::ram_wr_t   fr_wr;
  scfr_pkg::ram_rd_t   fr_rd;
  scfr_pkg::ram_rd_t   bk_rd;
  logic [7:0]          fr_rdata, bk_rdata;
  logic                q_push, q_pop, q_full, q_empty, acc_done;
  scfr_pkg::q_entry_t  q_entry, q_head;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_comb begin
    head_byte_nxt = head_byte_r;
    addr_byte_nxt = addr_byte_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        scfr_pkg::CFG_HEAD_BYTE: head_byte_nxt = cfg_data;
        scfr_pkg::CFG_ADDR_BYTE: addr_byte_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_byte_r <= scfr_pkg::HEAD_BYTE_RST;
      addr_byte_r <= scfr_pkg::ADDR_BYTE_RST;
    end else begin
      head_byte_r <= head_byte_nxt;
      addr_byte_r <= addr_byte_nxt;
    end
  end

  // Byte parser.
  scfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .head_byte (head_byte_r),
    .addr_byte (addr_byte_r),
    .wr        (fr_wr),
    .cmp_rd    (fr_rd),
    .cmp_rdata (fr_rdata),
    .q_push    (q_push),
    .q_entry   (q_entry),
    .q_full    (q_full),
    .acc_done  (acc_done)
  );

  // Frame queue.
  scfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  // Result sequencer.
  scfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .rd        (bk_rd),
    .rdata     (bk_rdata),
    .acc_done  (acc_done),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Payload buffer: two banks, selected per byte position.
  scfr_ram #(
    .WIDTH (8),
    .DEPTH (scfr_pkg::RAM_DEPTH)
  ) u_payload_ram (
    .clk     (clk),
    .we      (fr_wr.we),
    .waddr   (fr_wr.addr),
    .wdata   (fr_wr.data),
    .re_a    (fr_rd.re),
    .raddr_a (fr_rd.addr),
    .rdata_a (fr_rdata),
    .re_b    (bk_rd.re),
    .raddr_b (bk_rd.addr),
    .rdata_b (bk_rdata)
  );

  // The parser must never overwrite a byte the sequencer is reading.
  a_no_read_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (fr_wr.we && bk_rd.re) |-> (fr_wr.addr != bk_rd.addr))
    else $error("payload write hits a byte being read for output");

endmodule

@@ tb/frame_scoreboard_pkg.sv @@
// Scoreboard for the sum/add-check frame receiver: byte-level frame predictor and result check.
// Depends on scfr_pkg for the payload structs, phase and status codes.
`timescale 1ns / 1ps

package frame_scoreboard_pkg;

  import scfr_pkg::*;

  class frame_scoreboard;

    // Configuration as last written.
    logic [7:0] head_byte;
    logic [7:0] addr_byte;

    // Parser state of the current burst.
    logic [2:0] phase;
    logic [2:0] burst_count;
    logic [5:0] frame_pos;
    logic       prev_was_head;
    logic [7:0] id_reg;
    logic [7:0] len_reg;
    logic [7:0] sum_acc;
    logic [7:0] add_acc;
    logic [7:0] sum_rx;
    logic [7:0] add_rx;
    logic       same_so_far;
    logic [7:0] payload_store [MAX_PAYLOAD];
    logic [7:0] prev_payload [MAX_PAYLOAD];

    // Results predicted but not yet seen on the output.
    out_item_t  pending_results [$];
    int unsigned errors;

    function new();
      head_byte = HEAD_BYTE_RST;
      addr_byte = ADDR_BYTE_RST;
      errors    = 0;
      foreach (prev_payload[i]) begin
        prev_payload[i]  = '0;
        payload_store[i] = '0;
      end
      clear_burst();
    endfunction

    function void clear_burst();
      phase         = PH_HUNT;
      burst_count   = '0;
      frame_pos     = '0;
      prev_was_head = 1'b0;
      id_reg        = '0;
      len_reg       = '0;
      sum_acc       = '0;
      add_acc       = '0;
      sum_rx        = '0;
      add_rx        = '0;
      same_so_far   = 1'b1;
    endfunction

    // Writes to indexes other than the two registers are ignored.
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      if (idx == CFG_HEAD_BYTE) begin
        head_byte = val;
      end else if (idx == CFG_ADDR_BYTE) begin
        addr_byte = val;
      end
    endfunction

    // Both checks run over every header and payload byte.
    function void absorb(logic [7:0] b);
      sum_acc = sum_acc + b;
      add_acc = add_acc + sum_acc;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // Advances the parser by one accepted byte and queues the results of a burst end.
    function void note_byte(in_item_t item);
      logic [7:0] b;
      logic [2:0] st;
      out_item_t  r;
      b = item.rx_byte;
      if (burst_count < MIN_BURST) burst_count++;

      case (phase)
        PH_HUNT: begin
          if (prev_was_head && b == addr_byte) begin
            sum_acc = '0;
            add_acc = '0;
            absorb(head_byte);
            absorb(addr_byte);
            phase = PH_ID;
          end
          prev_was_head = (b == head_byte);
        end
        PH_ID: begin
          id_reg = b;
          absorb(b);
          phase = PH_LEN;
        end
        PH_LEN: begin
          len_reg = b;
          absorb(b);
          frame_pos = '0;
          if (b > MAX_PAYLOAD) begin
            phase = PH_SKIP;
          end else if (b == 0) begin
            phase = PH_SUM;
          end else begin
            phase = PH_DATA;
          end
        end
        PH_DATA: begin
          payload_store[frame_pos] = b;
          if (prev_payload[frame_pos] != b) same_so_far = 1'b0;
          absorb(b);
          frame_pos++;
          if (frame_pos >= len_reg) phase = PH_SUM;
        end
        PH_SUM: begin
          sum_rx = b;
          phase = PH_ADD;
        end
        PH_ADD: begin
          add_rx = b;
          phase = PH_DONE;
        end
        default: ;
      endcase

      if (!item.burst_end) return;

      // Rejections are ranked: too short, no header, length, then checksum.
      if (burst_count < MIN_BURST) begin
        st = ST_SHORT;
      end else if (phase == PH_HUNT) begin
        st = ST_NOHDR;
      end else if (phase != PH_DONE) begin
        st = ST_LEN;
      end else if (add_acc == 0 || sum_rx != sum_acc || add_rx != add_acc) begin
        st = ST_CSUM;
      end else begin
        st = same_so_far ? ST_REPEAT : ST_NEW;
      end

      r = '0;
      r.status = st;
      r.last   = 1'b1;
      if (st == ST_NEW || st == ST_REPEAT) begin
        r.frame_id = id_reg;
        if (len_reg == 0) begin
          pending_results.push_back(r);
        end else begin
          for (int k = 0; k < len_reg; k++) begin
            r.payload_len = len_reg[LEN_W-1:0];
            r.byte_index  = POS_W'(k);
            r.data_byte   = payload_store[k];
            r.last        = (k == len_reg - 1);
            pending_results.push_back(r);
            prev_payload[k] = payload_store[k];
          end
        end
      end else begin
        foreach (prev_payload[i]) prev_payload[i] = '0;
        pending_results.push_back(r);
      end
      clear_burst();
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Compares one output transaction with the oldest prediction.
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d data %0d",
                 $time, got.status, got.data_byte);
        return;
      end
      want = pending_results.pop_front();
      check_field("status", want.status, got.status);
      check_field("frame_id", want.frame_id, got.frame_id);
      check_field("payload_len", want.payload_len, got.payload_len);
      check_field("byte_index", want.byte_index, got.byte_index);
      check_field("data_byte", want.data_byte, got.data_byte);
      check_field("last", want.last, got.last);
    endfunction

    function void flag_leftover();
      if (pending_results.size() != 0) begin
        errors++;
        $display("%0t: missing results, expected %0d more, actual 0", $time,
                 pending_results.size());
      end
    endfunction

  endclass

endpackage

@@ tb/testbench.sv @@
// Testbench for the sum/add-check frame receiver: directed and random bursts, random idling.
// Depends on scfr_pkg, frame_scoreboard_pkg and sum_add_check_frame_receiver_top.
`timescale 1ns / 1ps

module testbench;

  import scfr_pkg::*;
  import frame_scoreboard_pkg::*;

  typedef logic [7:0] byte_q_t [$];

  // Index outside the register map, used to check that such writes are ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 4'd9;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  frame_scoreboard sb;
  byte_q_t         burst_bytes;
  byte_q_t         last_payload;
  bit              steady;
  int              bytes_sent;

  sum_add_check_frame_receiver_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Idle cycles before the next transaction; none during steady stretches.
  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 3);
  endfunction

  // Appends a complete frame with correct check bytes to the current burst.
  function automatic void add_frame(logic [7:0] id, logic [7:0] len_field, byte_q_t pl);
    logic [7:0] s;
    logic [7:0] a;
    byte_q_t    frame;
    frame = {sb.head_byte, sb.addr_byte, id, len_field};
    foreach (pl[i]) frame.push_back(pl[i]);
    s = '0;
    a = '0;
    foreach (frame[i]) begin
      s = s + frame[i];
      a = a + s;
      burst_bytes.push_back(frame[i]);
    end
    burst_bytes.push_back(s);
    burst_bytes.push_back(a);
  endfunction

  // Sends one byte transaction after a random gap and waits until it is taken.
  task automatic send_item(in_item_t item);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    sb.note_byte(item);
    bytes_sent++;
  endtask

  // Sends the current burst, marking its final byte as the burst end.
  task automatic send_burst();
    in_item_t item;
    for (int i = 0; i < burst_bytes.size(); i++) begin
      item.rx_byte   = burst_bytes[i];
      item.burst_end = (i == burst_bytes.size() - 1);
      send_item(item);
    end
    burst_bytes.delete();
  endtask

  // Holds the input idle until every predicted result has come out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Mostly well-formed frames with random content; the rest is noise or broken frames.
  task automatic send_random_burst();
    int         kind;
    int         len;
    int         pick;
    logic [7:0] b;
    logic [7:0] id;
    logic [7:0] len_field;
    byte_q_t    pl;
    kind = $urandom_range(0, 99);
    steady = ($urandom_range(0, 4) == 0);
    if (kind < 8) begin
      repeat ($urandom_range(1, 6)) burst_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 15) begin
      repeat ($urandom_range(7, 12)) burst_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      // Junk before the header, sometimes a lone head byte.
      repeat ($urandom_range(0, 3)) begin
        b = ($urandom_range(0, 3) == 0) ? sb.head_byte : 8'($urandom_range(0, 255));
        burst_bytes.push_back(b);
      end
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        len = $urandom_range(0, 6);
      end else if (pick < 19) begin
        len = $urandom_range(7, MAX_PAYLOAD - 1);
      end else begin
        len = MAX_PAYLOAD;
      end
      if ($urandom_range(0, 3) == 0) begin
        pl = last_payload;
      end else begin
        repeat (len) pl.push_back(8'($urandom_range(0, 255)));
      end
      id = 8'($urandom_range(0, 255));
      len_field = (kind < 20) ? 8'($urandom_range(MAX_PAYLOAD + 1, 255)) : 8'(pl.size());
      add_frame(id, len_field, pl);
      if (kind >= 20 && kind < 25) begin
        // Cut off before the end; no trailing bytes to fill the gap.
        repeat ($urandom_range(1, 3)) void'(burst_bytes.pop_back());
      end else begin
        if (kind >= 25 && kind < 30) begin
          burst_bytes[burst_bytes.size() - 2] ^= 8'($urandom_range(1, 255));
        end else if (kind >= 30 && kind < 35) begin
          burst_bytes[burst_bytes.size() - 1] ^= 8'($urandom_range(1, 255));
        end else if (kind >= 35) begin
          last_payload = pl;
        end
        repeat ($urandom_range(0, 2)) burst_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    send_burst();
  endtask

  // Result side: check each output transaction, then stall for a random count.
  initial begin : result_monitor
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_result(out_data);
        stall_left = draw_gap();
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    byte_q_t    pl;
    logic [7:0] d;
    logic [7:0] head_set [6];
    logic [7:0] addr_set [6];
    int         start_count;
    int         waited;

    sb = new();
    steady = 1'b0;
    bytes_sent = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed bursts under the reset header and address.
    // A one-byte burst and a six-byte empty frame are both too short.
    burst_bytes = {8'hAA};
    send_burst();
    pl.delete();
    add_frame(8'h01, 8'd0, pl);
    send_burst();

    // Seven bytes with two head bytes but no head and address pair.
    burst_bytes = {8'hAA, 8'hAA, 8'h00, 8'hFF, 8'h55, 8'h00, 8'hFF};
    send_burst();

    // Empty payload after one junk byte matches any stored payload.
    burst_bytes = {8'h00};
    add_frame(8'hFF, 8'd0, pl);
    send_burst();

    // Full payload of extreme values, then the same payload with trailing bytes.
    for (int k = 0; k < MAX_PAYLOAD; k++) pl.push_back((k % 2) ? 8'hFF : 8'h00);
    add_frame(8'h00, 8'(MAX_PAYLOAD), pl);
    send_burst();
    add_frame(8'h80, 8'(MAX_PAYLOAD), pl);
    burst_bytes.push_back(8'hAA);
    burst_bytes.push_back(8'hFF);
    send_burst();

    // Length one above the maximum.
    burst_bytes = {8'hAA, 8'hFF, 8'h01, 8'(MAX_PAYLOAD + 1), 8'h00, 8'h00, 8'h00};
    send_burst();

    // Frame cut off before its add-check byte.
    pl = {8'h11, 8'h22, 8'h33};
    add_frame(8'h05, 8'd3, pl);
    void'(burst_bytes.pop_back());
    send_burst();

    // Wrong sum check, then wrong add check.
    add_frame(8'h06, 8'd3, pl);
    burst_bytes[burst_bytes.size() - 2] ^= 8'h01;
    send_burst();
    add_frame(8'h07, 8'd3, pl);
    burst_bytes[burst_bytes.size() - 1] ^= 8'h80;
    send_burst();

    // Correct check bytes whose add check works out to zero: shifting the payload
    // byte by d shifts both checks by d.
    pl = {8'h00};
    add_frame(8'h09, 8'd1, pl);
    d = 8'h00 - burst_bytes[6];
    burst_bytes[4] += d;
    burst_bytes[5] += d;
    burst_bytes[6] += d;
    send_burst();

    // Head, stray byte, head, head, address: the frame starts at the last pair.
    burst_bytes = {8'hAA, 8'h12, 8'hAA};
    pl = {8'hFF};
    add_frame(8'hFE, 8'd1, pl);
    send_burst();

    // Largest length byte with the burst ending on its seventh byte.
    burst_bytes = {8'hAA, 8'hFF, 8'h03, 8'hFF, 8'h01, 8'h02, 8'h03};
    send_burst();

    // An unmapped register index must leave both registers alone.
    wait_idle();
    write_reg(CFG_SPARE_IDX, 8'h5A);

    // Random bursts under several header settings, the extremes among them.
    head_set = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, HEAD_BYTE_RST};
    addr_set = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, ADDR_BYTE_RST};
    head_set[4] = 8'($urandom_range(0, 255));
    addr_set[4] = 8'($urandom_range(0, 255));
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_reg(CFG_HEAD_BYTE, head_set[p]);
      write_reg(CFG_ADDR_BYTE, addr_set[p]);
      last_payload.delete();
      start_count = bytes_sent;
      while (bytes_sent - start_count < 35) send_random_burst();
    end

    // Drain, with a bound, then allow late or extra results to show up.
    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    sb.flag_leftover();
    repeat (16) @(posedge clk);

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard limit on the run time.
  initial begin : watchdog
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
